// ===== rtl/llh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Latency histogram package
// Shared widths, command and status codes.
// ----------------------------------------------------------------------------
package llh_pkg;
   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int HIST_BUCKETS_DEF  = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_FILTER = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_UNIT    = 1'd1;

   localparam logic [1:0] CMD_ENTRY = 2'd0;
   localparam logic [1:0] CMD_EXIT  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [1:0] UNIT_US = 2'd1;
   localparam logic [1:0] UNIT_MS = 2'd2;

   localparam logic [2:0] ST_STORED   = 3'd0;
   localparam logic [2:0] ST_FILTERED = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_NOSTART  = 3'd3;
   localparam logic [2:0] ST_COUNTED  = 3'd4;
   localparam logic [2:0] ST_READ     = 3'd5;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] thread_id;
      logic [31:0] group_id;
      logic [63:0] time_ns;
      logic [4:0]  bucket_select;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  bucket;
      logic [31:0] bucket_count;
   } rsp_type;
endpackage
`default_nettype wire

// ===== rtl/llh_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface llh_req_if;
   logic             valid;
   logic             ready;
   llh_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/llh_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface llh_rsp_if;
   logic             valid;
   logic             ready;
   llh_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/llh_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module llh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/llh_divlog.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scaled log2 unit
// Compares the elapsed time against the unit shifted by every power of two,
// which gives the floor log2 of the scaled time without a divider, and
// returns it saturated at the last bucket. Done is start passed through the stg1, stg2 and done registers.
// ----------------------------------------------------------------------------
module llh_divlog #(
   parameter int HIST_BUCKETS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [63:0]                     delta,
   input  wire logic [1:0]                      unit,
   output logic                                 done,
   output logic      [$clog2(HIST_BUCKETS)-1:0] slot
);
   import llh_pkg::*;

   localparam int SW = $clog2(HIST_BUCKETS);

   logic          stg1_ff, stg2_ff, done_ff;
   logic [63:0]   delta_ff;
   logic [19:0]   dvs_ff, dvs_in;
   logic [63:1]   ge_ff, ge_in;
   logic [5:0]    lg;
   logic [SW-1:0] slot_ff, slot_in;

   always_comb begin
      unique case (unit)
         UNIT_US: dvs_in = 20'd1000;
         UNIT_MS: dvs_in = 20'd1000000;
         default: dvs_in = 20'd1;
      endcase
   end

   always_comb begin
      for (int k = 1; k < 64; k++) begin
         ge_in[k] = ({20'd0, delta_ff} >= ({64'd0, dvs_ff} << k));
      end
   end

   always_comb begin
      lg = 6'd0;
      for (int k = 1; k < 64; k++) begin
         if (ge_ff[k]) begin
            lg = 6'(k);
         end
      end
   end

   always_comb begin
      if ({1'b0, lg} >= 7'(HIST_BUCKETS)) begin
         slot_in = SW'(HIST_BUCKETS - 1);
      end else begin
         slot_in = SW'(lg);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg1_ff <= 1'b0;
         stg2_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         stg1_ff <= start;
         stg2_ff <= stg1_ff;
         done_ff <= stg2_ff;
      end
      if (start) begin
         delta_ff <= delta;
         dvs_ff   <= dvs_in;
      end
      if (stg1_ff) begin
         ge_ff <= ge_in;
      end
      if (stg2_ff) begin
         slot_ff <= slot_in;
      end
   end

   assign done = done_ff;
   assign slot = slot_ff;
endmodule
`default_nettype wire

// ===== rtl/latency_log2_histogram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Log2 latency histogram
// Per-thread start table and log2 bucket counters of call latency.
// ----------------------------------------------------------------------------
// Sequencing: a filtered entry or an out-of-range read answers in the cycle after
// acceptance and an in-range read after the counter read state; an entry or an
// exit scans the table one entry per cycle and answers from a last compare state,
// and an exit that counts adds the log2 unit and counter read and write states.
// One command is in flight at a time; the next is accepted in the cycle after the
// response beat is taken. After reset, every counter is cleared before idle.
module latency_log2_histogram #(
   parameter int TABLE_ENTRIES = llh_pkg::TABLE_ENTRIES_DEF,
   parameter int HIST_BUCKETS  = llh_pkg::HIST_BUCKETS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   llh_req_if.sink                               req,
   llh_rsp_if.source                             rsp,
   input  wire logic                             csr_wr_en,
   input  wire logic [llh_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [llh_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import llh_pkg::*;

   localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int TD = 1 << TW;
   localparam int BW = $clog2(HIST_BUCKETS);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_SCAN  = 4'd2;
   localparam logic [3:0] S_LAST  = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;
   localparam logic [3:0] S_HRD   = 4'd5;
   localparam logic [3:0] S_HWR   = 4'd6;
   localparam logic [3:0] S_RRD   = 4'd7;
   localparam logic [3:0] S_RSP   = 4'd8;
   localparam logic [3:0] S_DIVW  = 4'd9;

   logic [3:0]    state_ff, state_in;
   logic [31:0]   filt_ff;
   logic [1:0]    unit_ff;
   req_type       cur_ff, cur_in;
   rsp_type       out_ff, out_in;
   logic [TD-1:0] valid_ff, valid_in;
   logic [TW:0]   scan_ff, scan_in;
   logic [TW-1:0] rd_idx_ff, rd_idx_in;
   logic          rd_live_ff, rd_live_in;
   logic          hit_ff, hit_in;
   logic [TW-1:0] hit_idx_ff, hit_idx_in;
   logic          free_ff, free_in;
   logic [TW-1:0] free_idx_ff, free_idx_in;
   logic [BW-1:0] clr_ff, clr_in;
   logic [BW-1:0] slot_ff, slot_in;

   logic [TW-1:0] t_rd_addr, t_wr_addr;
   logic          t_wr_en;
   logic [95:0]   t_rd_data;
   logic [BW-1:0] h_rd_addr, h_wr_addr;
   logic          h_wr_en;
   logic [31:0]   h_wr_data, h_rd_data;
   logic          div_start, div_done;
   logic [BW-1:0] div_slot;
   logic [63:0]   delta;
   logic          req_fire;

   llh_ram #(.WIDTH(96), .DEPTH(TD)) u_table (
      .clock  (clock),
      .wr_en  (t_wr_en),
      .wr_addr(t_wr_addr),
      .wr_data({cur_ff.thread_id, cur_ff.time_ns}),
      .rd_addr(t_rd_addr),
      .rd_data(t_rd_data)
   );

   llh_ram #(.WIDTH(32), .DEPTH(HIST_BUCKETS)) u_hist (
      .clock  (clock),
      .wr_en  (h_wr_en),
      .wr_addr(h_wr_addr),
      .wr_data(h_wr_data),
      .rd_addr(h_rd_addr),
      .rd_data(h_rd_data)
   );

   assign delta = cur_ff.time_ns - t_rd_data[63:0];

   llh_divlog #(.HIST_BUCKETS(HIST_BUCKETS)) u_divlog (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .delta(delta),
      .unit (unit_ff),
      .done (div_done),
      .slot (div_slot)
   );

   assign req.ready = (state_ff == S_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign rsp.valid = (state_ff == S_RSP);
   assign rsp.data  = out_ff;

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      out_in      = out_ff;
      valid_in    = valid_ff;
      scan_in     = scan_ff;
      rd_idx_in   = rd_idx_ff;
      rd_live_in  = 1'b0;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      clr_in      = clr_ff;
      slot_in     = slot_ff;
      t_rd_addr   = rd_idx_ff;
      t_wr_en     = 1'b0;
      t_wr_addr   = hit_idx_ff;
      h_rd_addr   = slot_ff;
      h_wr_en     = 1'b0;
      h_wr_addr   = slot_ff;
      h_wr_data   = h_rd_data + 32'd1;
      div_start   = 1'b0;

      if (rd_live_ff && valid_ff[rd_idx_ff] && !hit_ff
            && t_rd_data[95:64] == cur_ff.thread_id) begin
         hit_in     = 1'b1;
         hit_idx_in = rd_idx_ff;
      end

      unique case (state_ff)
         S_CLEAR: begin
            h_wr_en   = 1'b1;
            h_wr_addr = clr_ff;
            h_wr_data = '0;
            clr_in    = clr_ff + BW'(1);
            if (clr_ff == BW'(HIST_BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               cur_in  = req.data;
               hit_in  = 1'b0;
               free_in = 1'b0;
               scan_in = '0;
               out_in  = '0;
               priority case (req.data.cmd)
                  CMD_ENTRY: begin
                     if (filt_ff != 32'd0 && filt_ff != req.data.group_id) begin
                        out_in.status = ST_FILTERED;
                        state_in      = S_RSP;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  CMD_EXIT: state_in = S_SCAN;
                  CMD_READ: begin
                     out_in.status = ST_READ;
                     out_in.bucket = req.data.bucket_select;
                     if ({2'b0, req.data.bucket_select} < 7'(HIST_BUCKETS)) begin
                        slot_in   = BW'(req.data.bucket_select);
                        h_rd_addr = BW'(req.data.bucket_select);
                        state_in  = S_RRD;
                     end else begin
                        state_in = S_RSP;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            t_rd_addr  = scan_ff[TW-1:0];
            rd_idx_in  = scan_ff[TW-1:0];
            rd_live_in = 1'b1;
            if (!free_ff && !valid_ff[scan_ff[TW-1:0]]) begin
               free_in     = 1'b1;
               free_idx_in = scan_ff[TW-1:0];
            end
            scan_in = scan_ff + (TW+1)'(1);
            if (scan_ff == (TW+1)'(TABLE_ENTRIES - 1)) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            // Final compare lands this cycle through hit_in.
            if (cur_ff.cmd == CMD_ENTRY) begin
               if (hit_in || free_ff) begin
                  t_wr_en   = 1'b1;
                  t_wr_addr = hit_in ? hit_idx_in : free_idx_ff;
                  valid_in[t_wr_addr] = 1'b1;
                  out_in.status = ST_STORED;
               end else begin
                  out_in.status = ST_FULL;
               end
               state_in = S_RSP;
            end else if (hit_in) begin
               rd_idx_in = hit_idx_in;
               t_rd_addr = hit_idx_in;
               state_in  = S_DIVW;
            end else begin
               out_in.status = ST_NOSTART;
               state_in      = S_RSP;
            end
         end
         S_DIVW: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               slot_in  = div_slot;
               state_in = S_HRD;
            end
         end
         S_HRD: state_in = S_HWR;
         S_HWR: begin
            h_wr_en       = 1'b1;
            out_in.status = ST_COUNTED;
            out_in.bucket = 5'(slot_ff);
            out_in.bucket_count = h_wr_data;
            state_in      = S_RSP;
         end
         S_RRD: begin
            out_in.bucket_count = h_rd_data;
            state_in            = S_RSP;
         end
         S_RSP: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         valid_ff   <= '0;
         filt_ff    <= '0;
         unit_ff    <= '0;
         rd_live_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         valid_ff   <= valid_in;
         rd_live_ff <= rd_live_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_GROUP_FILTER: filt_ff <= csr_wr_data;
               CSR_TIME_UNIT:    unit_ff <= csr_wr_data[1:0];
               default:          filt_ff <= filt_ff;
            endcase
         end
      end
      cur_ff      <= cur_in;
      out_ff      <= out_in;
      scan_ff     <= scan_in;
      rd_idx_ff   <= rd_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      slot_ff     <= slot_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("Response changed while stalled.");
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !rsp.valid || $past(req.data.cmd) == CMD_ENTRY
         || $past(req.data.cmd) == CMD_READ)
      else $error("Response too early after a command.");
   assert property (@(posedge clock) disable iff (reset)
      h_wr_en && state_ff == S_HWR |-> out_in.bucket_count != '0 || h_rd_data == '1)
      else $error("Counter update lost.");
endmodule
`default_nettype wire

// ===== test/llh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency histogram checker
// Watches the command and result channels, keeps its own thread table and
// bucket counters, and compares every result beat with the predicted one.
// ----------------------------------------------------------------------------
module llh_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  llh_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  llh_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [llh_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [llh_pkg::CSR_DATA_W-1:0] csr_wr_data,
   output int                             fail_count,
   output int                             pending
);
   import llh_pkg::*;

   localparam int NTHREADS = TABLE_ENTRIES_DEF;
   localparam int NBUCKETS = HIST_BUCKETS_DEF;

   logic [31:0] group_sel;
   logic [1:0]  unit_sel;
   logic        thread_live [NTHREADS];
   logic [31:0] thread_tag  [NTHREADS];
   logic [63:0] thread_start[NTHREADS];
   logic [31:0] hist        [NBUCKETS];
   rsp_type     results_due [$];

   function automatic int thread_slot(input logic [31:0] tid);
      for (int i = 0; i < NTHREADS; i++)
         if (thread_live[i] && thread_tag[i] == tid) return i;
      return -1;
   endfunction

   task automatic predict_result(input req_type r);
      rsp_type     e;
      int          idx;
      logic [63:0] elapsed;
      int          slot;
      e = '0;
      idx = -1;
      case (r.cmd)
         CMD_ENTRY: begin
            if (group_sel != 0 && group_sel != r.group_id) begin
               e.status = ST_FILTERED;
            end else begin
               idx = thread_slot(r.thread_id);
               if (idx < 0)
                  for (int i = NTHREADS - 1; i >= 0; i--)
                     if (!thread_live[i]) idx = i;
               if (idx < 0) begin
                  e.status = ST_FULL;
               end else begin
                  thread_live[idx]  = 1'b1;
                  thread_tag[idx]   = r.thread_id;
                  thread_start[idx] = r.time_ns;
                  e.status = ST_STORED;
               end
            end
         end
         CMD_EXIT: begin
            idx = thread_slot(r.thread_id);
            if (idx < 0) begin
               e.status = ST_NOSTART;
            end else begin
               elapsed = r.time_ns - thread_start[idx];
               if (unit_sel == UNIT_US) elapsed = elapsed / 64'd1000;
               else if (unit_sel == UNIT_MS) elapsed = elapsed / 64'd1000000;
               slot = 0;
               while (elapsed > 1) begin
                  elapsed = elapsed >> 1;
                  slot++;
               end
               if (slot >= NBUCKETS) slot = NBUCKETS - 1;
               hist[slot] = hist[slot] + 32'd1;
               e.status = ST_COUNTED;
               e.bucket = 5'(slot);
               e.bucket_count = hist[slot];
            end
         end
         CMD_READ: begin
            e.status = ST_READ;
            e.bucket = r.bucket_select;
            e.bucket_count = (r.bucket_select < NBUCKETS) ? hist[r.bucket_select] : '0;
         end
         default: return;
      endcase
      results_due.push_back(e);
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         group_sel = '0;
         unit_sel = '0;
         for (int i = 0; i < NTHREADS; i++) thread_live[i] = 1'b0;
         for (int i = 0; i < NBUCKETS; i++) hist[i] = '0;
         results_due.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_GROUP_FILTER) group_sel = csr_wr_data;
            else if (csr_index == CSR_TIME_UNIT) unit_sel = csr_wr_data[1:0];
         end
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $error("Result beat with nothing expected: %p", rsp_data);
               fail_count++;
            end else begin
               e = results_due.pop_front();
               if (rsp_data.status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.bucket !== e.bucket) begin
                  $error("bucket expected %0d actual %0d", e.bucket, rsp_data.bucket);
                  fail_count++;
               end
               if (rsp_data.bucket_count !== e.bucket_count) begin
                  $error("bucket_count expected %0d actual %0d", e.bucket_count,
                         rsp_data.bucket_count);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) predict_result(req_data);
      end
      pending = results_due.size();
   end
endmodule

// ===== test/tb_latency_log2_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log2 latency histogram testbench
// Drives entry, exit and read commands in bursts under four filter and unit
// settings while the result side stalls; a checker predicts every beat.
// ----------------------------------------------------------------------------
module tb_latency_log2_histogram;
   import llh_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;
   int                    fail_count;
   int                    pending;
   int                    burst_left = 0;
   logic [63:0]           now_ns = '0;
   logic [31:0]           tid_pool [8];

   llh_req_if req ();
   llh_rsp_if rsp ();

   latency_log2_histogram dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   llh_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending(pending)
   );

   always #4 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
   end

   // The result side stalls in a random pattern of its own.
   always @(negedge clock) begin
      int phase;
      phase = $urandom_range(0, 99);
      if (reset) rsp.ready <= 1'b0;
      else if (phase < 8) rsp.ready <= 1'b1;
      else rsp.ready <= ($urandom_range(0, 3) != 0) || phase > 90;
   end

   task automatic send(input logic [1:0] cmd, input logic [31:0] tid,
                       input logic [31:0] gid, input logic [63:0] t,
                       input logic [4:0] sel);
      req_type r;
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 7)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      r.cmd = cmd;
      r.thread_id = tid;
      r.group_id = gid;
      r.time_ns = t;
      r.bucket_select = sel;
      req.data <= r;
      req.valid <= 1'b1;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
      if (burst_left == 0) req.valid <= 1'b0;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain;
      if (burst_left != 0) req.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (250) @(negedge clock);
   endtask

   task automatic random_phase(input int count, input logic [31:0] grp);
      logic [31:0] tid;
      logic [63:0] span;
      int          pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         tid = ($urandom_range(0, 9) == 0) ? $urandom : tid_pool[$urandom_range(0, 7)];
         case ($urandom_range(0, 5))
            0: span = $urandom_range(0, 3);
            1: span = $urandom_range(0, 5000);
            2: span = {32'd0, $urandom};
            3: span = {$urandom, $urandom};
            4: span = 64'd1 << $urandom_range(0, 63);
            default: span = $urandom_range(0, 20000000);
         endcase
         if (pick < 40) begin
            now_ns = {$urandom, $urandom};
            send(CMD_ENTRY, tid, ($urandom_range(0, 3) == 0) ? $urandom : grp,
                 now_ns, 5'($urandom));
         end else if (pick < 80) begin
            send(CMD_EXIT, tid, $urandom, now_ns + span, 5'($urandom));
         end else if (pick < 95) begin
            send(CMD_READ, $urandom, $urandom, {$urandom, $urandom}, 5'($urandom));
         end else begin
            send(2'd3, $urandom, $urandom, {$urandom, $urandom}, 5'($urandom));
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 8; i++) tid_pool[i] = $urandom;
      tid_pool[0] = 32'd0;
      tid_pool[1] = 32'hFFFF_FFFF;

      // Directed: extremes, zero elapsed time, saturation, exit keeps entry.
      send(CMD_EXIT, 32'd5, 32'd0, 64'd10, 5'd0);
      send(CMD_ENTRY, 32'd0, 32'hFFFF_FFFF, 64'd0, 5'd31);
      send(CMD_EXIT, 32'd0, 32'd0, 64'd0, 5'd0);
      send(CMD_EXIT, 32'd0, 32'd0, 64'd1, 5'd0);
      send(CMD_EXIT, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0);
      send(CMD_ENTRY, 32'hFFFF_FFFF, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0);
      send(CMD_EXIT, 32'hFFFF_FFFF, 32'd0, 64'd5, 5'd0);
      send(CMD_ENTRY, 32'hFFFF_FFFF, 32'd0, 64'd100, 5'd0);
      send(CMD_EXIT, 32'hFFFF_FFFF, 32'd0, 64'd100, 5'd0);
      send(CMD_READ, 32'd0, 32'd0, 64'd0, 5'd0);
      send(CMD_READ, 32'd0, 32'd0, 64'd0, 5'd31);
      send(CMD_READ, 32'd0, 32'd0, 64'd0, 5'd2);
      send(2'd3, 32'd0, 32'd0, 64'd0, 5'd0);
      // Fill the table and overflow it.
      for (int i = 0; i < TABLE_ENTRIES_DEF + 2; i++)
         send(CMD_ENTRY, 32'h1000 + i, 32'd0, 64'(i), 5'd0);
      send(CMD_ENTRY, 32'h1001, 32'd0, 64'd7, 5'd0);
      drain();

      csr_write(CSR_GROUP_FILTER, 32'hFFFF_FFFF);
      csr_write(CSR_TIME_UNIT, 32'd1);
      send(CMD_ENTRY, 32'd9, 32'd1, 64'd0, 5'd0);
      send(CMD_ENTRY, 32'd9, 32'hFFFF_FFFF, 64'd0, 5'd0);
      random_phase(400, 32'hFFFF_FFFF);
      drain();

      csr_write(CSR_GROUP_FILTER, 32'd7);
      csr_write(CSR_TIME_UNIT, 32'd2);
      random_phase(400, 32'd7);
      drain();

      csr_write(CSR_TIME_UNIT, 32'd3);
      random_phase(300, 32'd7);
      drain();

      csr_write(CSR_GROUP_FILTER, 32'd0);
      csr_write(CSR_TIME_UNIT, 32'd0);
      random_phase(500, 32'd0);
      drain();

      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule
